FILE: hdl/periodic_task_timer_table_assert.svh
// ---------------------------------------------------------------------------
// periodic_task_timer_table assertion macros
// Shared forms for the concurrent checks of the task timer table.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TASK_TIMER_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PTT_ASSERT_NOW(name, clk_i, rst_i, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error("periodic_task_timer_table: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define PTT_ASSERT_NEXT(name, clk_i, rst_i, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error("periodic_task_timer_table: next-cycle check failed");

`endif

FILE: hdl/ptt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ptt_pkg
// Types, codes and widths shared by the periodic task timer table.
// ---------------------------------------------------------------------------
package ptt_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int MAX_RESULTS    = 16;
  localparam int NRES_W         = $clog2(MAX_RESULTS + 1);

  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 3;
  localparam int SLOT_IDX_W = 4;
  localparam int TAG_W      = 16;
  localparam int TIME_W     = 32;
  localparam int RUNS_W     = 8;

  localparam logic [RUNS_W-1:0] RUNS_MAX = '1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_ADD,
    S_DISP,
    S_DFIN
  } state_t;

  typedef enum logic {
    ALU_TICK,
    ALU_DISPATCH
  } alu_op_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] ticks;
    logic [TIME_W-1:0] period;
    logic [RUNS_W-1:0] runs;
  } slot_entry_t;

  typedef struct packed {
    logic ready;     // pending runs present
    logic one_shot;  // zero reload period
  } slot_flags_t;

endpackage
`default_nettype wire

FILE: hdl/ptt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ptt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                            wr_data,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: hdl/ptt_slot_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ptt_slot_alu
// Shared slot update unit: ages a slot on a tick, takes a run off on dispatch.
// ---------------------------------------------------------------------------
module ptt_slot_alu (
  input  wire ptt_pkg::alu_op_t     op,
  input  wire ptt_pkg::slot_entry_t entry_in,
  output ptt_pkg::slot_entry_t      entry_out,
  output ptt_pkg::slot_flags_t      flags
);

  always_comb begin
    entry_out      = entry_in;
    flags.ready    = (entry_in.runs != '0);
    flags.one_shot = (entry_in.period == '0);
    case (op)
      ptt_pkg::ALU_TICK: begin
        if (entry_in.ticks == '0) begin
          // saturate the pending count, reload only from a nonzero period
          if (entry_in.runs != ptt_pkg::RUNS_MAX) begin
            entry_out.runs = entry_in.runs + 1'b1;
          end
          if (entry_in.period != '0) begin
            entry_out.ticks = entry_in.period;
          end
        end else begin
          entry_out.ticks = entry_in.ticks - 1'b1;
        end
      end
      ptt_pkg::ALU_DISPATCH: begin
        entry_out.runs = entry_in.runs - 1'b1;
      end
      default: begin
        entry_out = entry_in;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/periodic_task_timer_table.sv
// Delete, clear and undefined commands: result strobe in the cycle after start, no busy.
// Tick: busy while every slot is walked, one result at the end. Add: result for the
// first free slot k, or status full when the table is full.
// Dispatch: results streamed as due slots are found.
// The walk is set by the slot RAM's single read port: one slot per cycle.
// Synchronous reset empties every slot at once through the per-slot valid bits.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// periodic_task_timer_table
// Time-triggered task slot table with tick, add, delete, dispatch and clear.
// ---------------------------------------------------------------------------
`include "periodic_task_timer_table_assert.svh"

module periodic_task_timer_table #(
  parameter int SLOT_COUNT = ptt_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [ptt_pkg::CMD_W-1:0]       command,
  input  wire logic [ptt_pkg::TAG_W-1:0]       task_tag,
  input  wire logic [ptt_pkg::TIME_W-1:0]      first_delay,
  input  wire logic [ptt_pkg::TIME_W-1:0]      repeat_period,
  input  wire logic [ptt_pkg::SLOT_IDX_W-1:0]  slot_select,
  output logic                                 done,
  output logic      [ptt_pkg::STATUS_W-1:0]    status,
  output logic      [ptt_pkg::SLOT_IDX_W-1:0]  slot_index,
  output logic      [ptt_pkg::TAG_W-1:0]       due_tag,
  output logic                                 last
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [CNT_W-1:0] WALK_END = CNT_W'(SLOT_COUNT);
  localparam logic [ptt_pkg::NRES_W-1:0] RES_CAP = ptt_pkg::NRES_W'(ptt_pkg::MAX_RESULTS);

  ptt_pkg::state_t state, state_next;

  logic [CNT_W-1:0]            rd_idx, rd_idx_next;
  logic                        p1_vld, p1_vld_next;
  logic [IDX_W-1:0]            p1_idx, p1_idx_next;
  logic [SLOT_COUNT-1:0]       used, used_next;
  logic                        held_vld, held_vld_next;
  logic [ptt_pkg::SLOT_IDX_W-1:0] held_slot, held_slot_next;
  logic [ptt_pkg::TAG_W-1:0]   held_tag, held_tag_next;
  logic [ptt_pkg::NRES_W-1:0]  n_res, n_res_next;
  logic [ptt_pkg::TAG_W-1:0]   add_tag, add_tag_next;
  logic [ptt_pkg::TIME_W-1:0]  add_delay, add_delay_next;
  logic [ptt_pkg::TIME_W-1:0]  add_period, add_period_next;

  logic                          emit;
  logic [ptt_pkg::STATUS_W-1:0]  emit_status;
  logic [ptt_pkg::SLOT_IDX_W-1:0] emit_slot;
  logic [ptt_pkg::TAG_W-1:0]     emit_tag;
  logic                          emit_last;

  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  ptt_pkg::slot_entry_t   wr_data;
  logic [IDX_W-1:0]       rd_addr;
  ptt_pkg::slot_entry_t   rd_data;

  ptt_pkg::alu_op_t       alu_op;
  ptt_pkg::slot_entry_t   alu_out;
  ptt_pkg::slot_flags_t   alu_flags;

  logic [IDX_W-1:0]       del_idx;
  logic                   del_out_of_range;

  ptt_ram #(
    .WIDTH ($bits(ptt_pkg::slot_entry_t)),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ptt_slot_alu u_slot_alu (
    .op        (alu_op),
    .entry_in  (rd_data),
    .entry_out (alu_out),
    .flags     (alu_flags)
  );

  assign del_idx          = IDX_W'(slot_select);
  assign del_out_of_range = (32'(slot_select) >= 32'(SLOT_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx   <= '0;
      p1_vld   <= 1'b0;
      used     <= '0;
      held_vld <= 1'b0;
      n_res    <= '0;
      done     <= 1'b0;
    end else begin
      rd_idx   <= rd_idx_next;
      p1_vld   <= p1_vld_next;
      used     <= used_next;
      held_vld <= held_vld_next;
      n_res    <= n_res_next;
      done     <= emit;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx     <= p1_idx_next;
    held_slot  <= held_slot_next;
    held_tag   <= held_tag_next;
    add_tag    <= add_tag_next;
    add_delay  <= add_delay_next;
    add_period <= add_period_next;
    status     <= emit_status;
    slot_index <= emit_slot;
    due_tag    <= emit_tag;
    last       <= emit_last;
  end

  always_comb begin
    state_next      = state;
    rd_idx_next     = rd_idx;
    p1_vld_next     = 1'b0;
    p1_idx_next     = rd_idx[IDX_W-1:0];
    used_next       = used;
    held_vld_next   = held_vld;
    held_slot_next  = held_slot;
    held_tag_next   = held_tag;
    n_res_next      = n_res;
    add_tag_next    = add_tag;
    add_delay_next  = add_delay;
    add_period_next = add_period;

    rd_addr = rd_idx[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = p1_idx;
    wr_data = alu_out;
    alu_op  = (state == ptt_pkg::S_DISP) ? ptt_pkg::ALU_DISPATCH : ptt_pkg::ALU_TICK;

    emit        = 1'b0;
    emit_status = ptt_pkg::ST_DONE;
    emit_slot   = '0;
    emit_tag    = '0;
    emit_last   = 1'b1;

    case (state)
      ptt_pkg::S_IDLE: begin
        if (start) begin
          rd_idx_next     = '0;
          add_tag_next    = task_tag;
          add_delay_next  = first_delay;
          add_period_next = repeat_period;
          case (command)
            ptt_pkg::CMD_TICK: begin
              state_next = ptt_pkg::S_TICK;
            end
            ptt_pkg::CMD_ADD: begin
              state_next = ptt_pkg::S_ADD;
            end
            ptt_pkg::CMD_DELETE: begin
              emit      = 1'b1;
              emit_slot = slot_select;
              if (del_out_of_range) begin
                emit_status = ptt_pkg::ST_EMPTY;
              end else begin
                emit_status        = used[del_idx] ? ptt_pkg::ST_DONE : ptt_pkg::ST_EMPTY;
                used_next[del_idx] = 1'b0;
              end
            end
            ptt_pkg::CMD_DISPATCH: begin
              state_next    = ptt_pkg::S_DISP;
              held_vld_next = 1'b0;
              n_res_next    = '0;
            end
            ptt_pkg::CMD_CLEAR: begin
              used_next = '0;
              emit      = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      ptt_pkg::S_TICK: begin
        if (rd_idx != WALK_END) begin
          rd_idx_next = rd_idx + 1'b1;
          p1_vld_next = 1'b1;
        end
        if (p1_vld && used[p1_idx]) begin
          wr_en = 1'b1;
        end
        if (rd_idx == WALK_END && !p1_vld) begin
          emit       = 1'b1;
          state_next = ptt_pkg::S_IDLE;
        end
      end

      ptt_pkg::S_ADD: begin
        if (rd_idx == WALK_END) begin
          emit        = 1'b1;
          emit_status = ptt_pkg::ST_FULL;
          state_next  = ptt_pkg::S_IDLE;
        end else if (!used[rd_idx[IDX_W-1:0]]) begin
          wr_en          = 1'b1;
          wr_addr        = rd_idx[IDX_W-1:0];
          wr_data.tag    = add_tag;
          wr_data.ticks  = add_delay;
          wr_data.period = add_period;
          wr_data.runs   = '0;
          used_next[rd_idx[IDX_W-1:0]] = 1'b1;
          emit       = 1'b1;
          emit_slot  = ptt_pkg::SLOT_IDX_W'(rd_idx[IDX_W-1:0]);
          state_next = ptt_pkg::S_IDLE;
        end else begin
          rd_idx_next = rd_idx + 1'b1;
        end
      end

      ptt_pkg::S_DISP: begin
        if (rd_idx != WALK_END) begin
          rd_idx_next = rd_idx + 1'b1;
          p1_vld_next = 1'b1;
        end
        if (p1_vld && used[p1_idx] && alu_flags.ready) begin
          // release the held item; it is not the last one
          if (held_vld) begin
            emit        = 1'b1;
            emit_status = ptt_pkg::ST_DUE;
            emit_slot   = held_slot;
            emit_tag    = held_tag;
            emit_last   = 1'b0;
          end
          held_vld_next  = 1'b1;
          held_slot_next = ptt_pkg::SLOT_IDX_W'(p1_idx);
          held_tag_next  = rd_data.tag;
          n_res_next     = ptt_pkg::NRES_W'(n_res + 1'b1);
          if (alu_flags.one_shot) begin
            used_next[p1_idx] = 1'b0;
          end else begin
            wr_en = 1'b1;
          end
          if (n_res_next == RES_CAP) begin
            state_next = ptt_pkg::S_DFIN;
          end
        end else if (rd_idx == WALK_END && !p1_vld) begin
          state_next = ptt_pkg::S_DFIN;
        end
      end

      ptt_pkg::S_DFIN: begin
        emit = 1'b1;
        if (held_vld) begin
          emit_status = ptt_pkg::ST_DUE;
          emit_slot   = held_slot;
          emit_tag    = held_tag;
        end else begin
          emit_status = ptt_pkg::ST_NONE;
        end
        held_vld_next = 1'b0;
        state_next    = ptt_pkg::S_IDLE;
      end

      default: begin
        state_next = ptt_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state != ptt_pkg::S_IDLE);

  `PTT_ASSERT_NEXT(a_start_reacts, clk, rst, start && !busy, busy || done)
  `PTT_ASSERT_NOW(a_only_due_streams, clk, rst, done && !last, status == ptt_pkg::ST_DUE)
  `PTT_ASSERT_NOW(a_none_is_last, clk, rst, done && (status == ptt_pkg::ST_NONE), last)
  `PTT_ASSERT_NOW(a_held_counted, clk, rst, held_vld, (n_res != '0) && busy)

endmodule
`default_nettype wire
